// ===== sv/tbu_pkg.sv =====
// Shared constants, command codes and slot entry type for the timer bank.
package tbu_pkg;

   localparam int SLOTS   = 16;
   localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W   = $clog2(SLOTS + 1);
   localparam int COUNT_W = 31;
   localparam int UNIT_W  = 16;
   localparam int USE_W   = 5;

   localparam logic [COUNT_W-1:0] COUNT_MAX       = {COUNT_W{1'b1}};
   localparam logic [UNIT_W-1:0]  TIME_UNIT_RESET = 16'd100;

   localparam logic [1:0] CMD_TICK    = 2'd0;
   localparam logic [1:0] CMD_SCAN    = 2'd1;
   localparam logic [1:0] CMD_ENABLE  = 2'd2;
   localparam logic [1:0] CMD_DISABLE = 2'd3;

   localparam logic [1:0] CSR_TIME_UNIT    = 2'd0;
   localparam logic [1:0] CSR_SLOTS_IN_USE = 2'd1;

   typedef struct packed {
      logic               periodic;
      logic               fire_now;
      logic [COUNT_W-1:0] period;
      logic [COUNT_W-1:0] elapsed;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// ===== sv/software_timer_bank_unit.sv =====
// Timer bank top level: command sequencer, slot memory walk and result register.
// Sequence: enable/disable go from acceptance to the finish state, which registers the result
//   word once the result register is free; a tick or scan reads each visited slot, then updates
//   and writes it back in one walk, holding while a firing waits on a busy result register.
// One command at a time, taken in idle; ticks and scans visit min(slots_in_use,SLOTS) slots.
// Reset: synchronous, active high; clears all enables, time_unit to 100, slots_in_use to 0.
//   Slot memory is not cleared: a slot is only looked at once an enable has rewritten it.
module software_timer_bank_unit (
   input  logic                             clock,
   input  logic                             reset,
   // command channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_command,
   input  logic [3:0]                       req_slot,
   input  logic                             req_periodic,
   input  logic [30:0]                      req_period,
   input  logic                             req_fire_now,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_fired,
   output logic [3:0]                       rsp_fired_slot,
   output logic                             rsp_last,
   // configuration
   input  logic                             csr_we,
   input  logic [1:0]                       csr_index,
   input  logic [15:0]                      csr_wdata
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_EVAL = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0]                   state_ff, state_in;
   logic [tbu_pkg::UNIT_W-1:0]   time_unit_ff;
   logic [tbu_pkg::USE_W-1:0]    slots_use_ff;
   logic [tbu_pkg::SLOTS-1:0]    enabled_ff, enabled_in;
   logic [tbu_pkg::SLOT_W-1:0]   idx_ff, idx_in;
   logic [tbu_pkg::SLOT_W-1:0]   last_idx_ff, last_idx_in;
   logic                         tick_ff, tick_in;
   logic                         pend_valid_ff, pend_valid_in;
   logic [tbu_pkg::SLOT_W-1:0]   pend_slot_ff, pend_slot_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_fired_ff, rsp_fired_in;
   logic [3:0]                   rsp_slot_ff, rsp_slot_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                         accept;
   logic                         out_free;
   logic [tbu_pkg::CNT_W-1:0]    visit_n;
   logic [tbu_pkg::SLOT_W-1:0]   req_addr;
   logic                         req_in_range;

   logic                         wr_en;
   logic [tbu_pkg::SLOT_W-1:0]   wr_addr;
   tbu_pkg::entry_type           wr_entry;
   logic                         rd_en;
   tbu_pkg::entry_type           rd_entry;
   logic [tbu_pkg::ENTRY_W-1:0]  rd_bits;

   logic                         ev_fire;
   logic                         ev_enabled;
   tbu_pkg::entry_type           ev_entry;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign req_addr     = tbu_pkg::SLOT_W'(req_slot);
   assign req_in_range = (32'(req_slot) < tbu_pkg::SLOTS);

   // Clamp the visit count to the number of slots that exist.
   assign visit_n = (32'(slots_use_ff) > tbu_pkg::SLOTS) ? tbu_pkg::CNT_W'(tbu_pkg::SLOTS)
                                                         : tbu_pkg::CNT_W'(slots_use_ff);

   assign rd_entry = tbu_pkg::entry_type'(rd_bits);
   assign rd_en    = (state_ff == ST_READ);

   tbu_ram #(
      .WIDTH (tbu_pkg::ENTRY_W),
      .DEPTH (tbu_pkg::SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_bits)
   );

   tbu_slot_eval u_eval (
      .entry        (rd_entry),
      .enabled      (enabled_ff[idx_ff]),
      .tick         (tick_ff),
      .time_unit    (time_unit_ff),
      .fire         (ev_fire),
      .enabled_next (ev_enabled),
      .entry_next   (ev_entry)
   );

   always_comb begin
      state_in      = state_ff;
      enabled_in    = enabled_ff;
      idx_in        = idx_ff;
      last_idx_in   = last_idx_ff;
      tick_in       = tick_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_fired_in  = rsp_fired_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_entry      = ev_entry;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               tick_in       = (req_command == tbu_pkg::CMD_TICK);
               idx_in        = '0;
               last_idx_in   = tbu_pkg::SLOT_W'(visit_n - tbu_pkg::CNT_W'(1));
               pend_valid_in = 1'b0;
               case (req_command)
                  tbu_pkg::CMD_ENABLE: begin
                     // Load the whole entry so stale memory never matters.
                     if (req_in_range) begin
                        wr_en                = 1'b1;
                        wr_addr              = req_addr;
                        wr_entry.periodic    = req_periodic;
                        wr_entry.fire_now    = req_fire_now;
                        wr_entry.period      = req_period;
                        wr_entry.elapsed     = '0;
                        enabled_in[req_addr] = 1'b1;
                     end
                     state_in = ST_FIN;
                  end
                  tbu_pkg::CMD_DISABLE: begin
                     if (req_in_range) begin
                        enabled_in[req_addr] = 1'b0;
                     end
                     state_in = ST_FIN;
                  end
                  default: begin
                     state_in = (visit_n == '0) ? ST_FIN : ST_READ;
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            // A new firing pushes out the held one; hold here if that push finds the result slot busy.
            if (!(ev_fire && pend_valid_ff && !out_free)) begin
               wr_en              = enabled_ff[idx_ff];
               enabled_in[idx_ff] = ev_enabled;
               if (ev_fire) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_fired_in = 1'b1;
                     rsp_slot_in  = 4'(pend_slot_ff);
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_slot_in  = idx_ff;
               end
               if (idx_ff == last_idx_ff) begin
                  state_in = ST_FIN;
               end else begin
                  idx_in   = idx_ff + tbu_pkg::SLOT_W'(1);
                  state_in = ST_READ;
               end
            end
         end
         ST_FIN: begin
            // Drain the held firing as the final word, or report no firing.
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_fired_in  = pend_valid_ff;
               rsp_slot_in   = pend_valid_ff ? 4'(pend_slot_ff) : 4'd0;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         enabled_ff    <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         time_unit_ff  <= tbu_pkg::TIME_UNIT_RESET;
         slots_use_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         enabled_ff    <= enabled_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               tbu_pkg::CSR_TIME_UNIT:    time_unit_ff <= csr_wdata;
               tbu_pkg::CSR_SLOTS_IN_USE: slots_use_ff <= csr_wdata[tbu_pkg::USE_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      last_idx_ff  <= last_idx_in;
      tick_ff      <= tick_in;
      pend_slot_ff <= pend_slot_in;
      rsp_fired_ff <= rsp_fired_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_fired      = rsp_fired_ff;
   assign rsp_fired_slot = rsp_slot_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// ===== sv/tbu_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
module tbu_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== sv/tbu_slot_eval.sv =====
// Per-slot update: saturating tick add, fire decision and write-back entry.
module tbu_slot_eval (
   input  tbu_pkg::entry_type               entry,
   input  logic                             enabled,
   input  logic                             tick,
   input  logic [tbu_pkg::UNIT_W-1:0]       time_unit,
   output logic                             fire,
   output logic                             enabled_next,
   output tbu_pkg::entry_type               entry_next
);

   logic [tbu_pkg::COUNT_W:0]   sum;
   logic [tbu_pkg::COUNT_W-1:0] elapsed_new;

   always_comb begin
      sum = {1'b0, entry.elapsed} + {{(tbu_pkg::COUNT_W + 1 - tbu_pkg::UNIT_W){1'b0}}, time_unit};
      if (enabled && tick) begin
         elapsed_new = (sum >= {1'b0, tbu_pkg::COUNT_MAX}) ? tbu_pkg::COUNT_MAX
                                                           : sum[tbu_pkg::COUNT_W-1:0];
      end else begin
         elapsed_new = entry.elapsed;
      end

      fire = enabled && ((elapsed_new >= entry.period) || entry.fire_now);

      entry_next         = entry;
      entry_next.elapsed = elapsed_new;
      enabled_next       = enabled;
      if (fire) begin
         entry_next.fire_now = 1'b0;
         entry_next.elapsed  = '0;
         enabled_next        = entry.periodic;
      end
   end

endmodule

// ===== sim/software_timer_bank_unit_tb.sv =====
// Self-checking testbench for the timer bank: directed table, then random phases.
module software_timer_bank_unit_tb;

   // Generous cap on the run: about 470 words, plus one long hold-off.
   localparam int unsigned CYCLE_LIMIT       = 200_000;
   localparam int unsigned PHASE_WORDS       = 75;
   localparam int unsigned SQUEEZE_CYCLES    = 300;
   localparam int unsigned DRAIN_CYCLES      = 40;

   typedef struct packed {
      logic       fired;
      logic [3:0] fired_slot;
      logic       last;
   } fire_word_type;

   typedef enum logic {ROW_WORD, ROW_REG} row_kind_type;

   typedef struct packed {
      row_kind_type                kind;
      logic [1:0]                  code;     // command, or register index on a register row
      logic [3:0]                  slot;
      logic                        periodic;
      logic [tbu_pkg::COUNT_W-1:0] period;   // period, or register value on a register row
      logic                        fire_now;
      logic                        quiet;    // expect exactly one no-fire word
   } plan_row_type;

   // Directed opening: reset state, bank bounds, period extremes, fire-now corner cases
   // and the time unit at zero and at its maximum.
   localparam plan_row_type PLAN [27] = '{
      '{ROW_REG,  tbu_pkg::CSR_SLOTS_IN_USE, 4'd0,  1'b0, 31'd0,          1'b0, 1'b0},
      // nothing is enabled after reset
      '{ROW_WORD, tbu_pkg::CMD_TICK,         4'd9,  1'b1, 31'h7FFFFFFF,   1'b1, 1'b1},
      '{ROW_WORD, tbu_pkg::CMD_ENABLE,       4'd0,  1'b1, 31'd0,          1'b0, 1'b1},
      // slot 0 lies outside the slots in use, so it cannot fire
      '{ROW_WORD, tbu_pkg::CMD_SCAN,         4'd0,  1'b0, 31'd0,          1'b0, 1'b1},
      // slots in use above the bank size: visit all sixteen
      '{ROW_REG,  tbu_pkg::CSR_SLOTS_IN_USE, 4'd0,  1'b0, 31'd31,         1'b0, 1'b0},
      '{ROW_WORD, tbu_pkg::CMD_SCAN,         4'd0,  1'b0, 31'd0,          1'b0, 1'b0},
      '{ROW_WORD, tbu_pkg::CMD_ENABLE,       4'd15, 1'b0, 31'h7FFFFFFF,   1'b1, 1'b1},
      '{ROW_WORD, tbu_pkg::CMD_ENABLE,       4'd7,  1'b1, 31'd200,        1'b0, 1'b1},
      '{ROW_WORD, tbu_pkg::CMD_TICK,         4'd0,  1'b0, 31'd0,          1'b0, 1'b0},
      '{ROW_WORD, tbu_pkg::CMD_TICK,         4'd0,  1'b0, 31'd0,          1'b0, 1'b0},
      // disabled slot keeps its fire-now flag until re-enabled
      '{ROW_WORD, tbu_pkg::CMD_ENABLE,       4'd3,  1'b0, 31'd1,          1'b1, 1'b1},
      '{ROW_WORD, tbu_pkg::CMD_DISABLE,      4'd3,  1'b1, 31'h55555555,   1'b1, 1'b1},
      '{ROW_WORD, tbu_pkg::CMD_DISABLE,      4'd0,  1'b0, 31'd0,          1'b0, 1'b1},
      '{ROW_WORD, tbu_pkg::CMD_SCAN,         4'd0,  1'b0, 31'd0,          1'b0, 1'b0},
      '{ROW_WORD, tbu_pkg::CMD_ENABLE,       4'd3,  1'b1, 31'd5000,       1'b0, 1'b1},
      '{ROW_WORD, tbu_pkg::CMD_TICK,         4'd0,  1'b0, 31'd0,          1'b0, 1'b0},
      '{ROW_REG,  tbu_pkg::CSR_TIME_UNIT,    4'd0,  1'b0, 31'd0,          1'b0, 1'b0},
      '{ROW_WORD, tbu_pkg::CMD_TICK,         4'd0,  1'b0, 31'd0,          1'b0, 1'b0},
      '{ROW_WORD, tbu_pkg::CMD_SCAN,         4'd0,  1'b0, 31'd0,          1'b0, 1'b0},
      '{ROW_REG,  tbu_pkg::CSR_TIME_UNIT,    4'd0,  1'b0, 31'd65535,      1'b0, 1'b0},
      '{ROW_WORD, tbu_pkg::CMD_TICK,         4'd0,  1'b0, 31'd0,          1'b0, 1'b0},
      '{ROW_WORD, tbu_pkg::CMD_DISABLE,      4'd7,  1'b0, 31'd0,          1'b0, 1'b1},
      '{ROW_WORD, tbu_pkg::CMD_DISABLE,      4'd3,  1'b0, 31'd0,          1'b0, 1'b1},
      '{ROW_WORD, tbu_pkg::CMD_ENABLE,       4'd12, 1'b1, 31'h2AAAAAAA,   1'b1, 1'b1},
      '{ROW_WORD, tbu_pkg::CMD_SCAN,         4'd0,  1'b0, 31'd0,          1'b0, 1'b0},
      '{ROW_WORD, tbu_pkg::CMD_DISABLE,      4'd12, 1'b0, 31'd0,          1'b0, 1'b1},
      '{ROW_REG,  tbu_pkg::CSR_TIME_UNIT,    4'd0,  1'b0, 31'd100,        1'b0, 1'b0}
   };

   logic                        clock          = 1'b0;
   logic                        reset          = 1'b1;
   logic                        req_valid      = 1'b0;
   logic                        req_stall;
   logic [1:0]                  req_command    = tbu_pkg::CMD_SCAN;
   logic [3:0]                  req_slot       = 4'd0;
   logic                        req_periodic   = 1'b0;
   logic [tbu_pkg::COUNT_W-1:0] req_period     = '0;
   logic                        req_fire_now   = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_stall      = 1'b0;
   logic                        rsp_fired;
   logic [3:0]                  rsp_fired_slot;
   logic                        rsp_last;
   logic                        csr_we         = 1'b0;
   logic [1:0]                  csr_index      = tbu_pkg::CSR_TIME_UNIT;
   logic [tbu_pkg::UNIT_W-1:0]  csr_wdata      = '0;

   // Shadow of the bank: configuration and per-slot state.
   logic [tbu_pkg::UNIT_W-1:0]  unit_size;
   logic [tbu_pkg::USE_W-1:0]   visit_span;
   logic                        slot_on    [tbu_pkg::SLOTS];
   logic                        slot_rearm [tbu_pkg::SLOTS];
   logic                        slot_kick  [tbu_pkg::SLOTS];
   logic [tbu_pkg::COUNT_W-1:0] slot_limit [tbu_pkg::SLOTS];
   logic [tbu_pkg::COUNT_W-1:0] slot_count [tbu_pkg::SLOTS];

   fire_word_type fresh_q[$];   // words caused by the latest command
   fire_word_type fire_q[$];    // words still owed by the block, oldest first

   int          mismatches   = 0;
   int unsigned cycle_count  = 0;
   int unsigned hold_left    = 0;
   bit          calm         = 1'b0;
   bit          squeeze_arm  = 1'b0;
   bit          squeeze_done = 1'b0;

   software_timer_bank_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_slot       (req_slot),
      .req_periodic   (req_periodic),
      .req_period     (req_period),
      .req_fire_now   (req_fire_now),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_fired      (rsp_fired),
      .rsp_fired_slot (rsp_fired_slot),
      .rsp_last       (rsp_last),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Apply one command to the shadow bank; leave the words it causes in fresh_q.
   task automatic advance_bank(input logic [1:0] command, input logic [3:0] slot,
                               input logic periodic,
                               input logic [tbu_pkg::COUNT_W-1:0] period,
                               input logic fire_now);
      int unsigned   span;
      int            i;
      logic [31:0]   room;
      fire_word_type tail;
      fresh_q.delete();
      span = (32'(visit_span) > tbu_pkg::SLOTS) ? tbu_pkg::SLOTS : 32'(visit_span);
      if (command == tbu_pkg::CMD_ENABLE || command == tbu_pkg::CMD_DISABLE) begin
         if (command == tbu_pkg::CMD_ENABLE) begin
            slot_rearm[slot] = periodic;
            slot_limit[slot] = period;
            slot_kick[slot]  = fire_now;
            slot_count[slot] = '0;
            slot_on[slot]    = 1'b1;
         end else begin
            slot_on[slot] = 1'b0;
         end
         fresh_q.push_back('{1'b0, 4'd0, 1'b1});
      end else begin
         // advance time first, saturating at the top of the count
         if (command == tbu_pkg::CMD_TICK) begin
            for (i = 0; i < span; i++) begin
               if (slot_on[i]) begin
                  room = {1'b0, tbu_pkg::COUNT_MAX} - {1'b0, slot_count[i]};
                  if ({16'd0, unit_size} >= room)
                     slot_count[i] = tbu_pkg::COUNT_MAX;
                  else
                     slot_count[i] = slot_count[i] + {15'd0, unit_size};
               end
            end
         end
         for (i = 0; i < span; i++) begin
            if (slot_on[i] && (slot_count[i] >= slot_limit[i] || slot_kick[i])) begin
               slot_kick[i]  = 1'b0;
               slot_count[i] = '0;
               if (!slot_rearm[i])
                  slot_on[i] = 1'b0;
               fresh_q.push_back('{1'b1, 4'(i), 1'b0});
            end
         end
         if (fresh_q.size() == 0) begin
            fresh_q.push_back('{1'b0, 4'd0, 1'b1});
         end else begin
            tail      = fresh_q[fresh_q.size() - 1];
            tail.last = 1'b1;
            fresh_q[fresh_q.size() - 1] = tail;
         end
      end
   endtask

   // Offer one command word, wait for acceptance, then book what it owes.
   task automatic send_word(input logic [1:0] command, input logic [3:0] slot,
                            input logic periodic,
                            input logic [tbu_pkg::COUNT_W-1:0] period,
                            input logic fire_now, input logic quiet);
      csr_we <= 1'b0;
      if (!calm && $urandom_range(0, 99) < 9) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_command  <= command;
      req_slot     <= slot;
      req_periodic <= periodic;
      req_period   <= period;
      req_fire_now <= fire_now;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      advance_bank(command, slot, periodic, period, fire_now);
      // quiet rows carry their expectation in the table itself
      if (quiet)
         fire_q.push_back('{1'b0, 4'd0, 1'b1});
      else
         foreach (fresh_q[k]) fire_q.push_back(fresh_q[k]);
   endtask

   // Write a register once the bank has drained; leave the enable for the next caller to drop.
   task automatic write_reg(input logic [1:0] index, input logic [tbu_pkg::UNIT_W-1:0] value);
      req_valid <= 1'b0;
      while (fire_q.size() != 0) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      if (index == tbu_pkg::CSR_TIME_UNIT)
         unit_size = value;
      else if (index == tbu_pkg::CSR_SLOTS_IN_USE)
         visit_span = value[tbu_pkg::USE_W-1:0];
   endtask

   // Result side: check each accepted word, then pick the stall for the next cycle.
   always @(posedge clock) begin
      fire_word_type want;
      if (rsp_valid && !rsp_stall) begin
         if (fire_q.size() == 0) begin
            $error("rsp word with nothing expected: fired %0d fired_slot %0d last %0d",
                   rsp_fired, rsp_fired_slot, rsp_last);
            mismatches++;
         end else begin
            want = fire_q.pop_front();
            if (rsp_fired !== want.fired) begin
               $error("fired: expected %0d, got %0d", want.fired, rsp_fired);
               mismatches++;
            end
            if (rsp_fired_slot !== want.fired_slot) begin
               $error("fired_slot: expected %0d, got %0d", want.fired_slot, rsp_fired_slot);
               mismatches++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               mismatches++;
            end
         end
      end
      // one long hold-off so the block backs up and stalls its command side
      if (squeeze_arm && !squeeze_done) begin
         hold_left    = SQUEEZE_CYCLES;
         squeeze_done = 1'b1;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < 9);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("software_timer_bank_unit_tb: done, errors");
         $finish;
      end
   end

   initial begin
      int unsigned                 span;
      int unsigned                 pick;
      int unsigned                 choice;
      int unsigned                 phase;
      int unsigned                 n;
      logic [1:0]                  command;
      logic [3:0]                  slot;
      logic                        periodic;
      logic                        fire_now;
      logic [tbu_pkg::COUNT_W-1:0] period;
      logic [tbu_pkg::UNIT_W-1:0]  unit_pick;
      logic [tbu_pkg::USE_W-1:0]   span_pick;

      unit_size  = tbu_pkg::TIME_UNIT_RESET;
      visit_span = '0;
      for (n = 0; n < tbu_pkg::SLOTS; n++) begin
         slot_on[n]    = 1'b0;
         slot_rearm[n] = 1'b0;
         slot_kick[n]  = 1'b0;
         slot_limit[n] = '0;
         slot_count[n] = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the directed table
      foreach (PLAN[r]) begin
         if (PLAN[r].kind == ROW_REG)
            write_reg(PLAN[r].code, PLAN[r].period[tbu_pkg::UNIT_W-1:0]);
         else
            send_word(PLAN[r].code, PLAN[r].slot, PLAN[r].periodic, PLAN[r].period,
                      PLAN[r].fire_now, PLAN[r].quiet);
      end

      // random phases, each under its own configuration
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               unit_pick = 16'd1;
               span_pick = 5'd16;
            end
            1: begin
               unit_pick = 16'hFFFF;
               span_pick = 5'd1;
            end
            2: begin
               unit_pick = 16'($urandom);
               span_pick = 5'($urandom);
            end
            3: begin
               unit_pick = 16'd0;
               span_pick = 5'd17;
            end
            4: begin
               unit_pick = 16'($urandom_range(1, 300));
               span_pick = 5'd16;
            end
            default: begin
               unit_pick = 16'($urandom_range(20, 2000));
               span_pick = 5'($urandom_range(0, 31));
            end
         endcase
         write_reg(tbu_pkg::CSR_TIME_UNIT, unit_pick);
         write_reg(tbu_pkg::CSR_SLOTS_IN_USE, {11'd0, span_pick});
         // keep both sides free of random gaps and stalls for the whole of one phase
         calm = (phase == 4);
         for (n = 0; n < PHASE_WORDS; n++) begin
            if (phase == 2 && n == 20)
               squeeze_arm = 1'b1;
            span     = (32'(visit_span) > tbu_pkg::SLOTS) ? tbu_pkg::SLOTS : 32'(visit_span);
            pick     = $urandom_range(0, 99);
            slot     = 4'($urandom);
            periodic = 1'($urandom);
            fire_now = ($urandom_range(0, 99) < 20);
            period   = 31'($urandom);
            if (pick < 38)
               command = tbu_pkg::CMD_TICK;
            else if (pick < 50)
               command = tbu_pkg::CMD_SCAN;
            else if (pick < 82)
               command = tbu_pkg::CMD_ENABLE;
            else
               command = tbu_pkg::CMD_DISABLE;
            // mostly address slots that ticks and scans actually visit
            if ((command == tbu_pkg::CMD_ENABLE || command == tbu_pkg::CMD_DISABLE)
                && span != 0 && $urandom_range(0, 9) < 8)
               slot = 4'($urandom_range(0, span - 1));
            if (command == tbu_pkg::CMD_ENABLE) begin
               choice = $urandom_range(0, 9);
               if (choice == 0)
                  period = '0;
               else if (choice < 7)
                  period = 31'($urandom_range(0, 6 * unit_size));
               else if (choice == 7)
                  period = tbu_pkg::COUNT_MAX;
               else if (choice == 8)
                  period = 31'(unit_size * $urandom_range(1, 3));
            end
            send_word(command, slot, periodic, period, fire_now, 1'b0);
         end
      end
      calm = 1'b0;

      // drain, then give the block time to show any stray word
      req_valid <= 1'b0;
      csr_we    <= 1'b0;
      while (fire_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && fire_q.size() == 0)
         $display("software_timer_bank_unit_tb: done, clean");
      else
         $display("software_timer_bank_unit_tb: done, errors");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/tbu_pkg.sv
sv/tbu_ram.sv
sv/tbu_slot_eval.sv
sv/software_timer_bank_unit.sv
sim/software_timer_bank_unit_tb.sv
